// ===== design/owrl_pkg.sv =====
// Shared types, constants and the octant classifier for the octant winding region lookup.
package owrl_pkg;

  localparam int COORD_BITS             = 16;
  localparam int DIFF_BITS              = COORD_BITS + 1;
  localparam int REGION_COUNT_BITS      = 4;
  localparam int MAX_REGIONS_DEF        = 8;
  localparam int MAX_HULL_VERTICES_DEF  = 16;
  localparam logic [REGION_COUNT_BITS-1:0] REGION_COUNT_RESET = REGION_COUNT_BITS'(1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                         opcode;
    logic [2:0]                   region_sel;
    logic [3:0]                   vertex_index;
    logic                         last_vertex;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0] region_index;
    logic       inside_found;
  } out_item_t;

  typedef enum logic [1:0] {
    RD_LAST,
    RD_FIRST,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    start;
    logic    set_single;
    logic    sum_clear;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    diff;
    logic    shift;
    logic    acc_step;
    logic    mul_a;
    logic    mul_b;
    logic    acc_cross;
    logic    region_eval;
    logic    region_next;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_query;
    logic single;
    logic none;
    logic region_ok;
    logic region_last;
    logic vertex_last;
    logic opposite;
    logic out_busy;
  } dp_status_t;

  // Octant 0..7 of a vector, counterclockwise from the positive x axis.
  function automatic logic [2:0] octant_of(input logic signed [DIFF_BITS-1:0] x,
                                           input logic signed [DIFF_BITS-1:0] y);
    logic signed [DIFF_BITS:0] s;
    logic [2:0]                q;
    s = {x[DIFF_BITS-1], x} + {y[DIFF_BITS-1], y};
    if (!x[DIFF_BITS-1] && !y[DIFF_BITS-1]) begin
      q = (x > y) ? 3'd0 : 3'd1;
    end else if (x[DIFF_BITS-1] && !y[DIFF_BITS-1]) begin
      q = (s < 0) ? 3'd3 : 3'd2;
    end else if (x[DIFF_BITS-1] && y[DIFF_BITS-1]) begin
      q = (x < y) ? 3'd4 : 3'd5;
    end else begin
      q = (s > 0) ? 3'd7 : 3'd6;
    end
    return q;
  endfunction

endpackage

// ===== design/owrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module owrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/owrl_ctrl.sv =====
// Query sequencer: walks regions and hull vertices and drives the datapath.
module owrl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  owrl_pkg::dp_status_t status,
  output owrl_pkg::dp_cmd_t    cmd
);
  import owrl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSTART,
    S_DIFF,
    S_STEP,
    S_MUL_A,
    S_MUL_B,
    S_CROSS,
    S_RFIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   prime;
  logic   prime_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    prime_next = prime;
    case (state)
      S_IDLE: begin
        if (in_valid && status.in_query) begin
          cmd.start  = 1'b1;
          state_next = S_RSTART;
        end
      end
      S_RSTART: begin
        cmd.sum_clear = 1'b1;
        if (status.single) begin
          cmd.set_single = 1'b1;
          state_next     = S_DONE;
        end else if (status.none) begin
          state_next = S_DONE;
        end else if (!status.region_ok) begin
          state_next = S_RFIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LAST;
          prime_next = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (prime) begin
          // closing vertex only seeds the previous-vertex registers
          cmd.shift  = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_FIRST;
          prime_next = 1'b0;
          state_next = S_DIFF;
        end else if (status.opposite) begin
          state_next = S_MUL_A;
        end else begin
          cmd.acc_step = 1'b1;
          cmd.shift    = 1'b1;
          if (status.vertex_last) begin
            state_next = S_RFIN;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
            state_next = S_DIFF;
          end
        end
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_CROSS;
      end
      S_CROSS: begin
        cmd.acc_cross = 1'b1;
        cmd.shift     = 1'b1;
        if (status.vertex_last) begin
          state_next = S_RFIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_DIFF;
        end
      end
      S_RFIN: begin
        cmd.region_eval = 1'b1;
        if (status.region_last) begin
          state_next = S_DONE;
        end else begin
          cmd.region_next = 1'b1;
          state_next      = S_RSTART;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prime <= 1'b0;
    end else begin
      state <= state_next;
      prime <= prime_next;
    end
  end

endmodule

// ===== design/owrl_dp.sv =====
// Datapath: hull store, vertex counts, octant winding sum and result register.
module owrl_dp #(
  parameter int MAX_REGIONS       = owrl_pkg::MAX_REGIONS_DEF,
  parameter int MAX_HULL_VERTICES = owrl_pkg::MAX_HULL_VERTICES_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  owrl_pkg::in_item_t                         in_data,
  input  logic                                       in_fire,
  input  logic [owrl_pkg::REGION_COUNT_BITS-1:0]     cfg_data,
  input  logic                                       cfg_fire,
  input  owrl_pkg::dp_cmd_t                          cmd,
  output owrl_pkg::dp_status_t                       status,
  input  logic                                       out_ready,
  output logic                                       out_valid,
  output owrl_pkg::out_item_t                        out_data
);
  import owrl_pkg::*;

  localparam int DEPTH = MAX_REGIONS * MAX_HULL_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int VW    = $clog2(MAX_HULL_VERTICES);
  localparam int CW    = $clog2(MAX_HULL_VERTICES + 1);
  localparam int SUM_W = $clog2(4 * MAX_HULL_VERTICES + 1) + 1;
  localparam int PW    = 2 * DIFF_BITS;

  localparam logic signed [SUM_W-1:0] SUM_PLUS8  = SUM_W'(8);
  localparam logic signed [SUM_W-1:0] SUM_MINUS8 = SUM_W'(-8);
  localparam logic signed [SUM_W-1:0] STEP_POS4  = SUM_W'(4);
  localparam logic signed [SUM_W-1:0] STEP_NEG4  = SUM_W'(-4);

  logic [REGION_COUNT_BITS-1:0]  region_count;
  logic [CW-1:0]                 vcount [MAX_REGIONS];
  logic [RW-1:0]                 region;
  logic [VW-1:0]                 vi;
  logic [VW-1:0]                 vi_next;
  logic signed [COORD_BITS-1:0]  px;
  logic signed [COORD_BITS-1:0]  py;
  logic signed [DIFF_BITS-1:0]   dx0;
  logic signed [DIFF_BITS-1:0]   dy0;
  logic signed [DIFF_BITS-1:0]   dx1;
  logic signed [DIFF_BITS-1:0]   dy1;
  logic [2:0]                    q0;
  logic signed [PW-1:0]          prod_a;
  logic signed [PW-1:0]          prod_b;
  logic signed [SUM_W-1:0]       sum;
  logic                          found;
  logic [2:0]                    idx;

  logic [CW-1:0]                 n_cur;
  logic [7:0]                    used;
  logic [2:0]                    q1;
  logic [2:0]                    qd;
  logic                          load_we;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  logic [2*COORD_BITS-1:0]       rdata;
  logic signed [COORD_BITS-1:0]  rd_x;
  logic signed [COORD_BITS-1:0]  rd_y;
  logic                          closed;

  // load path: write straight from the accepted transfer
  assign load_we = in_fire && (in_data.opcode == OP_LOAD)
                   && (int'(in_data.region_sel) < MAX_REGIONS)
                   && (int'(in_data.vertex_index) < MAX_HULL_VERTICES);
  assign waddr   = AW'(AW'(in_data.region_sel) * AW'(MAX_HULL_VERTICES)
                       + AW'(in_data.vertex_index));

  assign n_cur = vcount[region];
  assign used  = (8'(region_count) > 8'(MAX_REGIONS)) ? 8'(MAX_REGIONS)
                                                      : 8'(region_count);

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST:  vi_next = VW'(n_cur - CW'(1));
      RD_FIRST: vi_next = '0;
      RD_NEXT:  vi_next = VW'(vi + VW'(1));
      default:  vi_next = '0;
    endcase
  end

  assign raddr = AW'(AW'(region) * AW'(MAX_HULL_VERTICES) + AW'(vi_next));

  owrl_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (DEPTH)
  ) u_hull_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata ({in_data.coord_x, in_data.coord_y}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_x = rdata[2*COORD_BITS-1:COORD_BITS];
  assign rd_y = rdata[COORD_BITS-1:0];

  // octant step wrapped to 3 bits: -4 marks opposite octants
  assign q1     = octant_of(dx1, dy1);
  assign qd     = q1 - q0;
  assign closed = (sum == SUM_PLUS8) || (sum == SUM_MINUS8);

  always_comb begin
    status.in_query    = (in_data.opcode == OP_QUERY);
    status.single      = (used == 8'd1);
    status.none        = (used == 8'd0);
    status.region_ok   = (n_cur >= CW'(3)) && (n_cur <= CW'(MAX_HULL_VERTICES));
    status.region_last = ((8'(region) + 8'd1) == used);
    status.vertex_last = (CW'(vi) == CW'(n_cur - CW'(1)));
    status.opposite    = (qd == 3'b100);
    status.out_busy    = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= REGION_COUNT_RESET;
      out_valid    <= 1'b0;
      for (int g = 0; g < MAX_REGIONS; g++) begin
        vcount[g] <= '0;
      end
    end else begin
      if (cfg_fire) begin
        region_count <= cfg_data;
      end
      for (int g = 0; g < MAX_REGIONS; g++) begin
        if (load_we && in_data.last_vertex && (int'(in_data.region_sel) == g)) begin
          vcount[g] <= CW'({1'b0, in_data.vertex_index} + 5'd1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px     <= in_data.coord_x;
      py     <= in_data.coord_y;
      found  <= 1'b0;
      idx    <= '0;
      region <= '0;
    end
    if (cmd.region_next) begin
      region <= RW'(region + RW'(1));
    end
    if (cmd.rd_en) begin
      vi <= vi_next;
    end
    if (cmd.diff) begin
      dx1 <= {rd_x[COORD_BITS-1], rd_x} - {px[COORD_BITS-1], px};
      dy1 <= {rd_y[COORD_BITS-1], rd_y} - {py[COORD_BITS-1], py};
    end
    if (cmd.shift) begin
      dx0 <= dx1;
      dy0 <= dy1;
      q0  <= q1;
    end
    if (cmd.mul_a) begin
      prod_a <= dx0 * dy1;
    end
    if (cmd.mul_b) begin
      prod_b <= dy0 * dx1;
    end
    if (cmd.sum_clear) begin
      sum <= '0;
    end else if (cmd.acc_step) begin
      sum <= sum + {{(SUM_W-3){qd[2]}}, qd};
    end else if (cmd.acc_cross) begin
      sum <= sum + ((prod_a > prod_b) ? STEP_POS4 : STEP_NEG4);
    end
    if (cmd.set_single) begin
      found <= 1'b1;
      idx   <= '0;
    end
    if (cmd.region_eval && closed) begin
      found <= 1'b1;
      idx   <= 3'(region);
    end
    if (cmd.out_load) begin
      out_data.region_index <= idx;
      out_data.inside_found <= found;
    end
  end

endmodule

// ===== design/octant_winding_region_lookup.sv =====
// Top level of the octant winding region lookup: controller, datapath and checks.
//
// Point-in-region lookup over up to MAX_REGIONS closed hull polygons. A load
// transfer (opcode 0) writes one hull vertex into the vertex RAM in the cycle
// it is accepted and, when last_vertex is set, fixes that region's vertex count
// at vertex_index plus one; loads give no result. A query transfer (opcode 1)
// walks every region in use and every stored vertex of each region with at
// least three vertices through a single RAM read port, summing octant steps
// around the hull; opposite octants are resolved by the sign of the cross
// product, formed with one 17x17 multiplier pass per product. Regions with
// fewer than three vertices are not walked and never match. The last region
// whose sum is +8 or -8 is reported, and region_index is 0 when none matches.
// With region_count of 1 every query answers region 0, found. The vertex RAM
// read port paces the walk, one vertex at a time. Loads are accepted back to
// back while the input is open. A finished result waits in the output register
// while loads keep flowing; a following query is still accepted and walked,
// but its result holds with the input closed until the waiting result is taken.
// region_count is written through the cfg channel, which is always ready, and
// must only be written while no query is in flight.
module octant_winding_region_lookup #(
  parameter int MAX_REGIONS       = owrl_pkg::MAX_REGIONS_DEF,
  parameter int MAX_HULL_VERTICES = owrl_pkg::MAX_HULL_VERTICES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  owrl_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output owrl_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [owrl_pkg::REGION_COUNT_BITS-1:0] cfg_data
);
  import owrl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_fire;

  // a transfer on the input channel; loads complete in this same cycle
  assign in_fire   = in_valid && in_ready;
  // the single config register takes every write at once
  assign cfg_ready = 1'b1;

  owrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  owrl_dp #(
    .MAX_REGIONS       (MAX_REGIONS),
    .MAX_HULL_VERTICES (MAX_HULL_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .in_fire   (in_fire),
    .cfg_data  (cfg_data),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A result only appears while a query is being worked on.
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a query in flight");

  // A query transfer closes the input; it reopens once its result is loaded into the output register.
  a_query_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.opcode == OP_QUERY)) |=> !in_ready)
    else $error("input still open after a query transfer");

  // A miss always reports region zero.
  a_miss_reports_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.inside_found) |-> (out_data.region_index == 3'd0))
    else $error("miss reported a nonzero region");

endmodule
